// ----- design/evr_pkg.sv -----
// evr_pkg: shared types, constants and the arctangent table for the
// Euler vector rotation block. No dependencies.
package evr_pkg;

  localparam int unsigned CW = 34;   // CORDIC datapath width
  localparam int unsigned TW = 33;   // cosine/sine width, Q2.30
  localparam int unsigned VW = 35;   // intermediate vector width

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [16:0] TWO_TURNS = 17'd46080;
  localparam logic [16:0] ONE_TURN  = 17'd23040;
  localparam int HALF_UNITS    = 11520;
  localparam int QUARTER_UNITS = 5760;
  // floor(x/90) for x below 5761 equals (x*RECIP_A) >> 20
  localparam logic [13:0] RECIP_A = 14'd11651;
  // floor(n/90) for n below 2^31 equals (n*RECIP_B) >> 38
  localparam logic [31:0] RECIP_B = 32'd3054198967;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
  } cs_t;

  function automatic logic signed [CW-1:0] atan_bam(input int unsigned i);
    logic signed [CW-1:0] v;
    case (i)
      0: v = 34'sd536870912;   1: v = 34'sd316933406;  2: v = 34'sd167458907;
      3: v = 34'sd85004756;    4: v = 34'sd42667331;   5: v = 34'sd21354465;
      6: v = 34'sd10679838;    7: v = 34'sd5340245;    8: v = 34'sd2670163;
      9: v = 34'sd1335087;    10: v = 34'sd667544;    11: v = 34'sd333772;
      12: v = 34'sd166886;    13: v = 34'sd83443;     14: v = 34'sd41722;
      15: v = 34'sd20861;     16: v = 34'sd10430;     17: v = 34'sd5215;
      18: v = 34'sd2608;      19: v = 34'sd1304;      20: v = 34'sd652;
      21: v = 34'sd326;       22: v = 34'sd163;       23: v = 34'sd81;
      24: v = 34'sd41;        25: v = 34'sd20;        26: v = 34'sd10;
      27: v = 34'sd5;         28: v = 34'sd3;         29: v = 34'sd1;
      30: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/evr_angle_prep.sv -----
// evr_angle_prep: reduces one angle to +-90 degrees and converts it to a
// binary angle seeding a CORDIC lane. Three register stages. Uses evr_pkg.
module evr_angle_prep (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [15:0]   angle,
  output evr_pkg::lane_t       lane
);
  import evr_pkg::*;

  logic [12:0] mag;
  logic        sgn1, neg1;
  logic [6:0]  quo, rem;
  logic        sgn2, neg2;

  logic [16:0]        t0, t1, t2;
  logic signed [15:0] r0, r1;
  logic               neg0;
  logic [26:0]        qprod;
  logic [6:0]         qv;
  logic [12:0]        q90;
  logic [30:0]        num;
  logic [62:0]        fprod;
  logic [30:0]        zmag;

  always_comb begin
    t0 = 17'($signed({angle[15], angle}) + 17'sd46080);
    t1 = (t0 >= TWO_TURNS) ? t0 - TWO_TURNS : t0;
    t2 = (t1 >= ONE_TURN) ? t1 - ONE_TURN : t1;
    r0 = 16'(t2);
    if (r0 > 16'(HALF_UNITS)) r0 = r0 - 16'sd23040;
    neg0 = 1'b0;
    r1 = r0;
    if (r0 > 16'(QUARTER_UNITS)) begin
      r1 = r0 - 16'sd11520;
      neg0 = 1'b1;
    end else if (r0 < -16'(QUARTER_UNITS)) begin
      r1 = r0 + 16'sd11520;
      neg0 = 1'b1;
    end
    qprod = 27'(mag) * 27'(RECIP_A);
    qv    = qprod[26:20];
    q90   = 13'(qv) * 13'd90;
    num   = {rem, 24'd0} + 31'd45;
    fprod = 63'(num) * 63'(RECIP_B);
    zmag  = {quo, 24'd0} + 31'(fprod[62:38]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag  <= 13'(r1[15] ? -r1 : r1);
      sgn1 <= r1[15];
      neg1 <= neg0;
      quo  <= qv;
      rem  <= 7'(mag - q90);
      sgn2 <= sgn1;
      neg2 <= neg1;
      lane.x   <= GAIN_Q30;
      lane.y   <= '0;
      lane.z   <= sgn2 ? -$signed(34'(zmag)) : $signed(34'(zmag));
      lane.neg <= neg2;
    end
  end
endmodule

// ----- design/evr_cordic_cell.sv -----
// evr_cordic_cell: one CORDIC rotation step for the three angle lanes,
// passing the vector along. Uses evr_pkg.
module evr_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  evr_pkg::lane_t [2:0]  lane_in,
  input  evr_pkg::vec_t         vec_in,
  output evr_pkg::lane_t [2:0]  lane_out,
  output evr_pkg::vec_t         vec_out
);
  import evr_pkg::*;

  localparam logic signed [CW-1:0] ATAN = atan_bam(STEP);

  lane_t [2:0] nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nxt[k].neg = lane_in[k].neg;
      if (!lane_in[k].z[CW-1]) begin
        nxt[k].x = lane_in[k].x - (lane_in[k].y >>> STEP);
        nxt[k].y = lane_in[k].y + (lane_in[k].x >>> STEP);
        nxt[k].z = lane_in[k].z - ATAN;
      end else begin
        nxt[k].x = lane_in[k].x + (lane_in[k].y >>> STEP);
        nxt[k].y = lane_in[k].y - (lane_in[k].x >>> STEP);
        nxt[k].z = lane_in[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= nxt;
      vec_out  <= vec_in;
    end
  end
endmodule

// ----- design/evr_rotate_stage.sv -----
// evr_rotate_stage: rotates the pair (a, b) by (c, s) with Q2.30 products
// rounded half up; carries the third component. Two stages. Uses evr_pkg.
module evr_rotate_stage (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [evr_pkg::VW-1:0]  a,
  input  logic signed [evr_pkg::VW-1:0]  b,
  input  logic signed [evr_pkg::VW-1:0]  keep_in,
  input  evr_pkg::cs_t                   cs,
  output logic signed [evr_pkg::VW-1:0]  r1,
  output logic signed [evr_pkg::VW-1:0]  r2,
  output logic signed [evr_pkg::VW-1:0]  keep_out
);
  import evr_pkg::*;

  localparam int PW = VW + TW;

  logic signed [PW-1:0] pac, pbs, pas, pbc;
  logic signed [VW-1:0] keep1;
  logic signed [PW:0]   sum1, sum2;

  always_comb begin
    sum1 = (PW+1)'(pac) - (PW+1)'(pbs) + (PW+1)'(64'sd536870912);
    sum2 = (PW+1)'(pas) + (PW+1)'(pbc) + (PW+1)'(64'sd536870912);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pac      <= PW'(a) * PW'(cs.c);
      pbs      <= PW'(b) * PW'(cs.s);
      pas      <= PW'(a) * PW'(cs.s);
      pbc      <= PW'(b) * PW'(cs.c);
      keep1    <= keep_in;
      r1       <= VW'(sum1 >>> 30);
      r2       <= VW'(sum2 >>> 30);
      keep_out <= keep1;
    end
  end
endmodule

// ----- design/euler_vector_rotation_top.sv -----
// euler_vector_rotation_top: rotates a Q16.16 vector about Z, Y then X by
// three angles in 1/64 degree. Uses evr_pkg, evr_angle_prep, evr_cordic_cell and evr_rotate_stage.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | in_x, in_y, in_z, pitch_angle, yaw_angle, roll_angle
//  output  | out_valid | out_stall | out_x, out_y, out_z
//
// One word enters per cycle while out_stall does not hold the output word. The
// pipeline is made of three angle reduction stages, one CORDIC cell per step,
// the registers of each of the three rotations and one saturation register.
// Reset clears only the valid pipeline; payload registers are not reset.
// The whole pipeline holds while the output word is stalled, so in_stall
// follows out_stall whenever a word waits at the output.
module euler_vector_rotation_top #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  input  logic signed [15:0] pitch_angle,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] roll_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);
  import evr_pkg::*;

  localparam int unsigned LAT = CORDIC_STEPS + 10;

  logic [LAT-1:0] vld;
  logic           en;

  // advance everything unless the output word is held
  assign en        = !(vld[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // angle reduction, vector delayed alongside
  lane_t [2:0] lane [CORDIC_STEPS+1];
  vec_t        vec  [CORDIC_STEPS+1];
  vec_t        vdly [3];

  evr_angle_prep u_prep_roll  (.clk(clk), .en(en), .angle(roll_angle),  .lane(lane[0][0]));
  evr_angle_prep u_prep_yaw   (.clk(clk), .en(en), .angle(yaw_angle),   .lane(lane[0][1]));
  evr_angle_prep u_prep_pitch (.clk(clk), .en(en), .angle(pitch_angle), .lane(lane[0][2]));

  always_ff @(posedge clk) begin
    if (en) begin
      vdly[0] <= '{x: in_x, y: in_y, z: in_z};
      vdly[1] <= vdly[0];
      vdly[2] <= vdly[1];
    end
  end
  assign vec[0] = vdly[2];

  // chain of CORDIC cells, one step each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    evr_cordic_cell #(.STEP(i)) u_cell (
      .clk(clk), .en(en),
      .lane_in(lane[i]), .vec_in(vec[i]),
      .lane_out(lane[i+1]), .vec_out(vec[i+1])
    );
  end

  // fold the half-turn flip into cosine and sine
  cs_t cs_fin [3];
  for (genvar k = 0; k < 3; k++) begin : g_cs
    lane_t l;
    assign l = lane[CORDIC_STEPS][k];
    assign cs_fin[k].c = TW'(l.neg ? -l.x : l.x);
    assign cs_fin[k].s = TW'(l.neg ? -l.y : l.y);
  end

  // delay yaw and pitch terms to meet their rotation stages
  cs_t yaw_d [2];
  cs_t pit_d [4];
  always_ff @(posedge clk) begin
    if (en) begin
      yaw_d[0] <= cs_fin[1];
      yaw_d[1] <= yaw_d[0];
      pit_d[0] <= cs_fin[2];
      for (int j = 1; j < 4; j++) pit_d[j] <= pit_d[j-1];
    end
  end

  logic signed [VW-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
  vec_t vc;
  assign vc = vec[CORDIC_STEPS];

  // about Z: (x, y)
  evr_rotate_stage u_rot_roll (
    .clk(clk), .en(en), .a(VW'(vc.x)), .b(VW'(vc.y)), .keep_in(VW'(vc.z)),
    .cs(cs_fin[0]), .r1(x1), .r2(y1), .keep_out(z1)
  );
  // about Y: (z, x)
  evr_rotate_stage u_rot_yaw (
    .clk(clk), .en(en), .a(z1), .b(x1), .keep_in(y1),
    .cs(yaw_d[1]), .r1(z2), .r2(x2), .keep_out(y2)
  );
  // about X: (y, z)
  evr_rotate_stage u_rot_pitch (
    .clk(clk), .en(en), .a(y2), .b(z2), .keep_in(x2),
    .cs(pit_d[3]), .r1(y3), .r2(z3), .keep_out(x3)
  );

  function automatic logic signed [31:0] sat32(input logic signed [VW-1:0] v);
    logic signed [31:0] r;
    if (v > VW'(64'sd2147483647))       r = 32'sh7fffffff;
    else if (v < VW'(-64'sd2147483648)) r = 32'sh80000000;
    else                                r = 32'(v);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      out_x <= sat32(x3);
      out_y <= sat32(y3);
      out_z <= sat32(z3);
    end
  end
endmodule

// ----- design/evr_checker.sv -----
// evr_checker: port-level checks for euler_vector_rotation_top, bound to
// the top level below. No package dependency.
module evr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z
);
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid)
    else $error("input word withdrawn while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z))
    else $error("stalled output word changed");

  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no output backpressure");
endmodule

bind euler_vector_rotation_top evr_checker u_evr_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_x(out_x), .out_y(out_y), .out_z(out_z)
);
